FILE: src/rlut_pkg.sv
// Shared types and constants for the record log unread tracker.
// Used by every module in src; depends on nothing.
`default_nettype none

package rlut_pkg;

    localparam int NUM_RECORDS_DEF = 32;

    localparam int OP_W     = 3;
    localparam int IDX_FLD_W = 5;
    localparam int COUNT_W  = 8;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 8;
    localparam int FACTOR_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_GET       = 3'd1;
    localparam logic [OP_W-1:0] OP_MARK_READ = 3'd2;
    localparam logic [OP_W-1:0] OP_MARK_UNRD = 3'd3;
    localparam logic [OP_W-1:0] OP_REWIND    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_CURRENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FACTOR_TYPE    = 1'b1;

    typedef enum logic [1:0] {
        MARK_UNREAD = 2'd0,
        MARK_READ   = 2'd1,
        MARK_EMPTY  = 2'd2
    } mark_t;

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [STATUS_W-1:0] status;
        logic [FACTOR_W-1:0] factor;
    } rec_t;

endpackage

`default_nettype wire

FILE: src/rlut_mark_mem.sv
// Read-mark memory: one write port, one registered read port.
// Per-entry written bits make never-written entries read as empty. Uses rlut_pkg.
`default_nettype none

module rlut_mark_mem
    import rlut_pkg::*;
#(
    parameter int NUM_RECORDS = NUM_RECORDS_DEF,
    parameter int IDX_W = $clog2(NUM_RECORDS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire mark_t            wr_mark,
    input  wire logic [IDX_W-1:0] rd_addr,
    output mark_t                 rd_mark
);

    mark_t                  mark_mem [NUM_RECORDS];
    logic [NUM_RECORDS-1:0] written_reg;
    mark_t                  mark_q_reg;
    logic                   written_q_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mark_mem[wr_addr] <= wr_mark;
        end
        mark_q_reg <= mark_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg   <= '0;
            written_q_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            written_q_reg <= written_reg[rd_addr];
        end
    end

    assign rd_mark = written_q_reg ? mark_q_reg : MARK_EMPTY;

endmodule

`default_nettype wire

FILE: src/rlut_rec_mem.sv
// Record store (timestamp, alarm status, factor type) with a registered read.
// No reset: entries are undefined until written. Uses rlut_pkg.
`default_nettype none

module rlut_rec_mem
    import rlut_pkg::*;
#(
    parameter int NUM_RECORDS = NUM_RECORDS_DEF,
    parameter int IDX_W = $clog2(NUM_RECORDS)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire rec_t             wr_rec,
    input  wire logic [IDX_W-1:0] rd_addr,
    output rec_t                  rd_rec
);

    rec_t rec_mem [NUM_RECORDS];
    rec_t rd_rec_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rec_mem[wr_addr] <= wr_rec;
        end
        rd_rec_reg <= rec_mem[rd_addr];
    end

    assign rd_rec = rd_rec_reg;

endmodule

`default_nettype wire

FILE: src/rlut_seq.sv
// Sequencer: takes one request at a time and walks the mark memory one entry
// per cycle for scans and rewinds. Drives both memories. Uses rlut_pkg.
`default_nettype none

module rlut_seq
    import rlut_pkg::*;
#(
    parameter int NUM_RECORDS = NUM_RECORDS_DEF,
    parameter int IDX_W = $clog2(NUM_RECORDS)
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 always_current,
    input  wire logic [FACTOR_W-1:0]  factor_type,
    // request channel
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [OP_W-1:0]      op,
    input  wire logic [IDX_FLD_W-1:0] entry_index,
    input  wire logic                 use_current,
    input  wire logic [COUNT_W-1:0]   rewind_count,
    input  wire logic [STAMP_W-1:0]   timestamp,
    input  wire logic [STATUS_W-1:0]  alarm_status,
    // result channel
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      found,
    output logic [IDX_FLD_W-1:0]      found_index,
    output logic [STAMP_W-1:0]        rec_timestamp,
    output logic [STATUS_W-1:0]       rec_status,
    output logic [FACTOR_W-1:0]       rec_factor,
    // mark memory
    output logic                      mark_wr_en,
    output logic [IDX_W-1:0]          mark_wr_addr,
    output mark_t                     mark_wr_mark,
    output logic [IDX_W-1:0]          mark_rd_addr,
    input  wire mark_t                mark_rd,
    // record memory
    output logic                      rec_wr_en,
    output logic [IDX_W-1:0]          rec_wr_addr,
    output rec_t                      rec_wr_rec,
    output logic [IDX_W-1:0]          rec_rd_addr,
    input  wire rec_t                 rec_rd
);

    // one bit above the widest index so NUM_RECORDS itself fits in a compare
    localparam int CMP_W = (IDX_W > IDX_FLD_W) ? IDX_W + 1 : IDX_FLD_W + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_MARK,
        S_REWIND,
        S_GET_CUR,
        S_GET_CHK,
        S_SCAN,
        S_FETCH,
        S_LOAD,
        S_DONE
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      wp_reg, wp_next;
    logic [OP_W-1:0]       op_reg, op_next;
    logic [IDX_FLD_W-1:0]  entry_reg, entry_next;
    logic                  use_cur_reg, use_cur_next;
    logic [STAMP_W-1:0]    stamp_reg, stamp_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [COUNT_W-1:0]    rw_left_reg, rw_left_next;
    logic [IDX_W-1:0]      rw_idx_reg, rw_idx_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic [IDX_W-1:0]      chk_idx_reg, chk_idx_next;
    logic                  chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic                  found_reg, found_next;
    logic [IDX_FLD_W-1:0]  found_idx_reg, found_idx_next;
    rec_t                  rec_reg, rec_next;

    logic [IDX_W-1:0]      wp_inc;
    logic [CMP_W-1:0]      target_ext;
    logic [CMP_W-1:0]      k_ext;
    logic                  accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign wp_inc   = (wp_reg == IDX_W'(NUM_RECORDS - 1)) ? '0 : wp_reg + IDX_W'(1);
    assign target_ext = use_cur_reg ? CMP_W'(wp_reg) : CMP_W'(entry_reg);
    assign k_ext    = CMP_W'(k_reg);

    assign rec_rd_addr = k_reg;
    assign rec_wr_addr = wp_inc;
    assign rec_wr_rec  = '{stamp: stamp_reg, status: status_reg, factor: factor_type};
    assign rec_wr_en   = (state_reg == S_ADD);

    always_comb
    begin
        mark_wr_en   = 1'b0;
        mark_wr_addr = wp_inc;
        mark_wr_mark = MARK_UNREAD;
        mark_rd_addr = wp_reg;
        case (state_reg)
            S_ADD:
            begin
                mark_wr_en = 1'b1;
            end
            S_MARK:
            begin
                mark_wr_en   = (op_reg == OP_MARK_READ || op_reg == OP_MARK_UNRD)
                               && (target_ext < CMP_W'(NUM_RECORDS));
                mark_wr_addr = target_ext[IDX_W-1:0];
                mark_wr_mark = (op_reg == OP_MARK_READ) ? MARK_READ : MARK_UNREAD;
            end
            S_REWIND:
            begin
                mark_wr_en   = (rw_left_reg != '0) && (rw_idx_reg != '0);
                mark_wr_addr = rw_idx_reg - IDX_W'(1);
            end
            S_SCAN:
            begin
                mark_rd_addr = scan_idx_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        op_next        = op_reg;
        entry_next     = entry_reg;
        use_cur_next   = use_cur_reg;
        stamp_next     = stamp_reg;
        status_next    = status_reg;
        rw_left_next   = rw_left_reg;
        rw_idx_next    = rw_idx_reg;
        scan_idx_next  = scan_idx_reg;
        chk_idx_next   = chk_idx_reg;
        chk_vld_next   = chk_vld_reg;
        k_next         = k_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        rec_next       = rec_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next        = op;
                    entry_next     = entry_index;
                    use_cur_next   = use_current;
                    stamp_next     = timestamp;
                    status_next    = alarm_status;
                    rw_left_next   = rewind_count;
                    rw_idx_next    = wp_reg;
                    found_next     = 1'b0;
                    found_idx_next = '0;
                    rec_next       = '0;
                    case (op)
                        OP_ADD:       state_next = S_ADD;
                        OP_MARK_READ: state_next = S_MARK;
                        OP_MARK_UNRD: state_next = S_MARK;
                        OP_REWIND:    state_next = S_REWIND;
                        OP_GET:
                        begin
                            if (always_current)
                            begin
                                k_next     = wp_reg;
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                state_next = S_GET_CUR;
                            end
                        end
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_ADD:
            begin
                wp_next    = wp_inc;
                state_next = S_DONE;
            end
            S_MARK:
            begin
                state_next = S_DONE;
            end
            S_REWIND:
            begin
                // marks entries just below the write position, stopping at index 0
                if ((rw_left_reg == '0) || (rw_idx_reg == '0))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rw_left_next = rw_left_reg - COUNT_W'(1);
                    rw_idx_next  = rw_idx_reg - IDX_W'(1);
                end
            end
            S_GET_CUR:
            begin
                state_next = S_GET_CHK;
            end
            S_GET_CHK:
            begin
                if (mark_rd == MARK_UNREAD)
                begin
                    k_next     = wp_reg;
                    state_next = S_FETCH;
                end
                else
                begin
                    scan_idx_next = '0;
                    chk_vld_next  = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read one entry per cycle, check the previous one
                if (chk_vld_reg && (mark_rd == MARK_UNREAD))
                begin
                    k_next     = chk_idx_reg;
                    state_next = S_FETCH;
                end
                else if (chk_vld_reg && (chk_idx_reg == IDX_W'(NUM_RECORDS - 1)))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    chk_idx_next  = scan_idx_reg;
                    chk_vld_next  = 1'b1;
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                found_next     = 1'b1;
                found_idx_next = k_ext[IDX_FLD_W-1:0];
                rec_next       = rec_rd;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        entry_reg     <= entry_next;
        use_cur_reg   <= use_cur_next;
        stamp_reg     <= stamp_next;
        status_reg    <= status_next;
        rw_left_reg   <= rw_left_next;
        rw_idx_reg    <= rw_idx_next;
        scan_idx_reg  <= scan_idx_next;
        chk_idx_reg   <= chk_idx_next;
        chk_vld_reg   <= chk_vld_next;
        k_reg         <= k_next;
        found_reg     <= found_next;
        found_idx_reg <= found_idx_next;
        rec_reg       <= rec_next;
    end

    assign out_valid     = (state_reg == S_DONE);
    assign found         = found_reg;
    assign found_index   = found_idx_reg;
    assign rec_timestamp = rec_reg.stamp;
    assign rec_status    = rec_reg.status;
    assign rec_factor    = rec_reg.factor;

endmodule

`default_nettype wire

FILE: src/record_log_unread_tracker.sv
// Record log unread tracker. One request at a time; rewind marks min(rewind_count,
// write position) entries unread. Get-unread checks the current entry first (takes it
// directly with always_current) and on a miss scans from entry 0, one mark-memory
// read per cycle.
// The next request is taken the cycle after the result is accepted.
// Reset (async, active low): write position 0, every mark empty, config cleared.
`default_nettype none

module record_log_unread_tracker
    import rlut_pkg::*;
#(
    parameter int NUM_RECORDS = NUM_RECORDS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [OP_W-1:0]       op,
    input  wire logic [IDX_FLD_W-1:0]  entry_index,
    input  wire logic                  use_current,
    input  wire logic [COUNT_W-1:0]    rewind_count,
    input  wire logic [STAMP_W-1:0]    timestamp,
    input  wire logic [STATUS_W-1:0]   alarm_status,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       found,
    output logic [IDX_FLD_W-1:0]       found_index,
    output logic [STAMP_W-1:0]         rec_timestamp,
    output logic [STATUS_W-1:0]        rec_status,
    output logic [FACTOR_W-1:0]        rec_factor
);

    localparam int IDX_W = $clog2(NUM_RECORDS);

    logic                always_cur_reg;
    logic [FACTOR_W-1:0] factor_reg;

    logic             mark_wr_en;
    logic [IDX_W-1:0] mark_wr_addr;
    mark_t            mark_wr_mark;
    logic [IDX_W-1:0] mark_rd_addr;
    mark_t            mark_rd;
    logic             rec_wr_en;
    logic [IDX_W-1:0] rec_wr_addr;
    rec_t             rec_wr_rec;
    logic [IDX_W-1:0] rec_rd_addr;
    rec_t             rec_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            always_cur_reg <= 1'b0;
            factor_reg     <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_ALWAYS_CURRENT: always_cur_reg <= cfg_wdata[0];
                CFG_FACTOR_TYPE:    factor_reg     <= cfg_wdata[FACTOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    rlut_mark_mem #(
        .NUM_RECORDS (NUM_RECORDS),
        .IDX_W       (IDX_W)
    ) u_mark_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (mark_wr_en),
        .wr_addr (mark_wr_addr),
        .wr_mark (mark_wr_mark),
        .rd_addr (mark_rd_addr),
        .rd_mark (mark_rd)
    );

    rlut_rec_mem #(
        .NUM_RECORDS (NUM_RECORDS),
        .IDX_W       (IDX_W)
    ) u_rec_mem (
        .clk     (clk),
        .wr_en   (rec_wr_en),
        .wr_addr (rec_wr_addr),
        .wr_rec  (rec_wr_rec),
        .rd_addr (rec_rd_addr),
        .rd_rec  (rec_rd)
    );

    rlut_seq #(
        .NUM_RECORDS (NUM_RECORDS),
        .IDX_W       (IDX_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .always_current (always_cur_reg),
        .factor_type    (factor_reg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .entry_index    (entry_index),
        .use_current    (use_current),
        .rewind_count   (rewind_count),
        .timestamp      (timestamp),
        .alarm_status   (alarm_status),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .found          (found),
        .found_index    (found_index),
        .rec_timestamp  (rec_timestamp),
        .rec_status     (rec_status),
        .rec_factor     (rec_factor),
        .mark_wr_en     (mark_wr_en),
        .mark_wr_addr   (mark_wr_addr),
        .mark_wr_mark   (mark_wr_mark),
        .mark_rd_addr   (mark_rd_addr),
        .mark_rd        (mark_rd),
        .rec_wr_en      (rec_wr_en),
        .rec_wr_addr    (rec_wr_addr),
        .rec_wr_rec     (rec_wr_rec),
        .rec_rd_addr    (rec_rd_addr),
        .rec_rd         (rec_rd)
    );

endmodule

`default_nettype wire

FILE: dv/record_log_unread_tracker_tb.sv
// Self-checking testbench for record_log_unread_tracker: directed and random requests
// with random stalls on both sides, checked against an in-bench predictor of the ring.
// Depends on rlut_pkg and the record_log_unread_tracker RTL only.
module record_log_unread_tracker_tb;
    import rlut_pkg::*;

    localparam int NREC           = NUM_RECORDS_DEF;
    localparam int SEG_ITEMS      = 190;
    localparam int SETTLE_CYCLES  = NREC + 8;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    // op codes the block leaves unused
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [IDX_FLD_W-1:0] entry_index;
        logic                 use_current;
        logic [COUNT_W-1:0]   rewind_count;
        logic [STAMP_W-1:0]   timestamp;
        logic [STATUS_W-1:0]  alarm_status;
    } request_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_FLD_W-1:0] found_index;
        logic [STAMP_W-1:0]   rec_timestamp;
        logic [STATUS_W-1:0]  rec_status;
        logic [FACTOR_W-1:0]  rec_factor;
    } lookup_t;

    class unread_tracker_sb;
        int                  wr_pos;
        mark_t               marks [NREC];
        logic [STAMP_W-1:0]  stamps [NREC];
        logic [STATUS_W-1:0] statuses [NREC];
        logic [FACTOR_W-1:0] factors [NREC];
        bit                  written [NREC];
        bit                  always_cur;
        logic [FACTOR_W-1:0] factor_code;
        lookup_t             pending_lookups [$];
        int                  errors;
        int                  results_seen;
        int                  lookups;
        int                  hits;

        function new();
            wr_pos = 0;
            always_cur = 1'b0;
            factor_code = '0;
            for (int i = 0; i < NREC; i++)
            begin
                marks[i] = MARK_EMPTY;
                stamps[i] = '0;
                statuses[i] = '0;
                factors[i] = '0;
                written[i] = 1'b0;
            end
            errors = 0;
            results_seen = 0;
            lookups = 0;
            hits = 0;
        endfunction

        // index a get-unread would return now, -1 when none
        function int unread_hit();
            if (always_cur)
                return wr_pos;
            if (marks[wr_pos] == MARK_UNREAD)
                return wr_pos;
            for (int i = 0; i < NREC; i++)
                if (marks[i] == MARK_UNREAD)
                    return i;
            return -1;
        endfunction

        function void set_config(bit ac, logic [FACTOR_W-1:0] ft);
            always_cur = ac;
            factor_code = ft;
        endfunction

        function void log_request(request_t r);
            lookup_t exp;
            int      tgt;
            exp = '0;
            case (r.op)
                OP_ADD:
                begin
                    wr_pos = (wr_pos + 1) % NREC;
                    stamps[wr_pos] = r.timestamp;
                    statuses[wr_pos] = r.alarm_status;
                    factors[wr_pos] = factor_code;
                    written[wr_pos] = 1'b1;
                    marks[wr_pos] = MARK_UNREAD;
                end
                OP_GET:
                begin
                    lookups++;
                    tgt = unread_hit();
                    if (tgt >= 0)
                    begin
                        hits++;
                        exp.found = 1'b1;
                        exp.found_index = IDX_FLD_W'(tgt);
                        exp.rec_timestamp = stamps[tgt];
                        exp.rec_status = statuses[tgt];
                        exp.rec_factor = factors[tgt];
                    end
                end
                OP_MARK_READ, OP_MARK_UNRD:
                begin
                    tgt = r.use_current ? wr_pos : int'(r.entry_index);
                    if (tgt < NREC)
                        marks[tgt] = (r.op == OP_MARK_READ) ? MARK_READ : MARK_UNREAD;
                end
                OP_REWIND:
                begin
                    // clipped at entry 0, no wrap
                    for (int k = 1; k <= int'(r.rewind_count); k++)
                        if (wr_pos >= k)
                            marks[wr_pos - k] = MARK_UNREAD;
                end
                default: ;
            endcase
            pending_lookups.push_back(exp);
        endfunction

        function void check_lookup(lookup_t got);
            lookup_t exp;
            results_seen++;
            if (pending_lookups.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d with no request outstanding: found=%0b idx=%0d",
                             results_seen, got.found, got.found_index);
                return;
            end
            exp = pending_lookups.pop_front();
            if (got.found !== exp.found || got.found_index !== exp.found_index ||
                got.rec_timestamp !== exp.rec_timestamp || got.rec_status !== exp.rec_status ||
                got.rec_factor !== exp.rec_factor)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d exp found=%0b idx=%0d ts=%h st=%h fac=%h, %s",
                             results_seen, exp.found, exp.found_index, exp.rec_timestamp,
                             exp.rec_status, exp.rec_factor,
                             $sformatf("got found=%0b idx=%0d ts=%h st=%h fac=%h",
                                       got.found, got.found_index, got.rec_timestamp,
                                       got.rec_status, got.rec_factor));
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       op = '0;
    logic [IDX_FLD_W-1:0]  entry_index = '0;
    logic                  use_current = 1'b0;
    logic [COUNT_W-1:0]    rewind_count = '0;
    logic [STAMP_W-1:0]    timestamp = '0;
    logic [STATUS_W-1:0]   alarm_status = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [IDX_FLD_W-1:0]  found_index;
    logic [STAMP_W-1:0]    rec_timestamp;
    logic [STATUS_W-1:0]   rec_status;
    logic [FACTOR_W-1:0]   rec_factor;

    unread_tracker_sb sb;
    int sender_idle_pct = 30;
    int recv_idle_pct = 54;
    int issued = 0;
    int settings_applied = 0;
    int sweeps = 0;
    int fixups = 0;

    record_log_unread_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .op            (op),
        .entry_index   (entry_index),
        .use_current   (use_current),
        .rewind_count  (rewind_count),
        .timestamp     (timestamp),
        .alarm_status  (alarm_status),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .found_index   (found_index),
        .rec_timestamp (rec_timestamp),
        .rec_status    (rec_status),
        .rec_factor    (rec_factor)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin : result_side
        lookup_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.found = found;
            seen.found_index = found_index;
            seen.rec_timestamp = rec_timestamp;
            seen.rec_status = rec_status;
            seen.rec_factor = rec_factor;
            sb.check_lookup(seen);
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic request_t make_req(logic [OP_W-1:0] o, int idx, logic cur, int cnt,
                                          logic [STAMP_W-1:0] ts, logic [STATUS_W-1:0] st);
        request_t r;
        r.op = o;
        r.entry_index = IDX_FLD_W'(idx);
        r.use_current = cur;
        r.rewind_count = COUNT_W'(cnt);
        r.timestamp = ts;
        r.alarm_status = st;
        return r;
    endfunction

    function automatic request_t rand_request();
        request_t r;
        int       sel;
        r.entry_index = IDX_FLD_W'($urandom_range(0, NREC - 1));
        r.use_current = ($urandom_range(0, 99) < 30);
        r.rewind_count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 255))
                                                     : COUNT_W'($urandom_range(0, 6));
        r.timestamp = $urandom();
        r.alarm_status = STATUS_W'($urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 30)
            r.op = OP_ADD;
        else if (sel < 60)
            r.op = OP_GET;
        else if (sel < 75)
            r.op = OP_MARK_READ;
        else if (sel < 87)
            r.op = OP_MARK_UNRD;
        else if (sel < 95)
            r.op = OP_REWIND;
        else
            r.op = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
        return r;
    endfunction

    // Send one request. A get that would land on a never-written entry is turned
    // into a request that clears the way (mark that entry read, or add one).
    task automatic issue(request_t r);
        int k;
        if (r.op == OP_GET)
        begin
            k = sb.unread_hit();
            if (k >= 0 && !sb.written[k])
            begin
                fixups++;
                if (sb.always_cur)
                    r.op = OP_ADD;
                else
                begin
                    r.op = OP_MARK_READ;
                    r.use_current = 1'b0;
                    r.entry_index = IDX_FLD_W'(k);
                end
            end
        end
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= r.op;
        entry_index <= r.entry_index;
        use_current <= r.use_current;
        rewind_count <= r.rewind_count;
        timestamp <= r.timestamp;
        alarm_status <= r.alarm_status;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.log_request(r);
        issued++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_lookups.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(logic ac, logic [FACTOR_W-1:0] ft);
        cfg_wr_en <= 1'b1;
        cfg_addr <= CFG_ALWAYS_CURRENT;
        cfg_wdata <= CFG_DATA_W'(ac);
        @(posedge clk);
        cfg_addr <= CFG_FACTOR_TYPE;
        cfg_wdata <= ft;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_config(ac, ft);
        settings_applied++;
    endtask

    // mark every entry read, then look: nothing unread unless always_current
    task automatic read_sweep();
        for (int i = 0; i < NREC; i++)
            issue(make_req(OP_MARK_READ, i, 1'b0, $urandom_range(0, 255), $urandom(), 8'h00));
        issue(make_req(OP_GET, $urandom_range(0, NREC - 1), 1'b0, 0, $urandom(), 8'h00));
        sweeps++;
    endtask

    initial
    begin
        #(2 * TIMEOUT_CYCLES);
        $display("Timed out with %0d results outstanding", sb.pending_lookups.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int n;
        logic ac;
        logic [FACTOR_W-1:0] ft;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, with reset settings first
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_RSVD_5, 31, 1'b1, 255, 32'hFFFF_FFFF, 8'hFF));
        issue(make_req(OP_RSVD_7, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_ADD, 0, 1'b0, 0, 32'h0000_0000, 8'h00));
        issue(make_req(OP_ADD, 31, 1'b1, 255, 32'hFFFF_FFFF, 8'hFF));
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_MARK_READ, 0, 1'b1, 0, 32'h0, 8'h00));
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_MARK_READ, 1, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_MARK_UNRD, 31, 1'b0, 0, 32'h0, 8'h00));  // empty entry
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_MARK_UNRD, 1, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_REWIND, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_REWIND, 0, 1'b0, 255, 32'h0, 8'h00));    // clips at entry 0
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_MARK_UNRD, 0, 1'b1, 0, 32'h0, 8'h00));   // current wins over index
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        drain();
        apply_settings(1'b1, 8'hFF);
        issue(make_req(OP_ADD, 5, 1'b0, 0, 32'h8000_0001, 8'h5A));
        issue(make_req(OP_MARK_READ, 0, 1'b1, 0, 32'h0, 8'h00));
        issue(make_req(OP_GET, 0, 1'b0, 0, 32'h0, 8'h00));
        issue(make_req(OP_RSVD_6, 17, 1'b1, 128, 32'h1234_5678, 8'hA5));

        for (int seg = 0; seg < 6; seg++)
        begin
            drain();
            case (seg)
                0: begin ac = 1'b0; ft = FACTOR_W'($urandom_range(1, 254)); end
                1: begin ac = 1'b1; ft = 8'hFF; end
                2: begin ac = 1'b0; ft = 8'h00; end
                3: begin ac = 1'b1; ft = FACTOR_W'($urandom_range(0, 255)); end
                4: begin ac = 1'b0; ft = 8'hFF; end
                default: begin ac = 1'b1; ft = FACTOR_W'($urandom_range(0, 255)); end
            endcase
            apply_settings(ac, ft);
            if (seg < 2)
            begin
                sender_idle_pct = 30;
                recv_idle_pct = 54;
            end
            else if (seg < 4)
            begin
                sender_idle_pct = 54;
                recv_idle_pct = 30;
            end
            else
            begin
                sender_idle_pct = 0;
                recv_idle_pct = 0;
            end
            n = 0;
            while (n < SEG_ITEMS)
            begin
                if (n == SEG_ITEMS / 2 || $urandom_range(0, 99) == 0)
                    drain();
                if ($urandom_range(0, 199) == 0)
                begin
                    read_sweep();
                    n += NREC + 1;
                end
                else
                begin
                    issue(rand_request());
                    n++;
                end
            end
        end

        drain();
        $display("Sent %0d requests over %0d register settings; %0d lookups, %0d hits.",
                 issued, settings_applied, sb.lookups, sb.hits);
        $display("Stall mixes on both sides, %0d full read sweeps, %0d lookups redirected.",
                 sweeps, fixups);
        if (sb.errors == 0 && sb.pending_lookups.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_lookups.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
